>>> rtl/fwpb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwpb_pkg: shared definitions for the priority-bypass FIFO
// Sizes, command and status codes, and the per-cell control word.
// ----------------------------------------------------------------------------
package fwpb_pkg;

  localparam int QueueDepth = 16;
  localparam int DataWidth  = 32;
  localparam int KindWidth  = 8;
  localparam int CountWidth = $clog2(QueueDepth + 1);
  localparam int CmdWidth   = 3;
  localparam int StatWidth  = 2;

  // Reset value of the special kind register: ASCII 'E'.
  localparam logic [KindWidth-1:0] SpecialKindReset = 8'h45;

  typedef enum logic [CmdWidth-1:0] {
    CmdAppend = 3'd0,
    CmdPush   = 3'd1,
    CmdPop    = 3'd2,
    CmdServe  = 3'd3,
    CmdClear  = 3'd4
  } cmd_e;

  typedef enum logic [StatWidth-1:0] {
    StatOk        = 2'd0,
    StatFull      = 2'd1,
    StatEmpty     = 2'd2,
    StatNoSpecial = 2'd3
  } status_e;

  // What a cell loads at the next edge.
  typedef enum logic [1:0] {
    OpHold  = 2'd0,
    OpLoad  = 2'd1,
    OpLeft  = 2'd2,
    OpRight = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     serve;
    logic     occupied;
  } cell_ctrl_t;

endpackage

>>> rtl/fwpb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwpb_if: request and response channels of the priority-bypass FIFO
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface fwpb_req_if;
  logic                           valid;
  logic                           ready;
  logic [fwpb_pkg::CmdWidth-1:0]  command;
  logic [fwpb_pkg::KindWidth-1:0] client_kind;
  logic [31:0]                    client_data;

  modport source (output valid, output command, output client_kind,
                  output client_data, input ready);
  modport sink   (input valid, input command, input client_kind,
                  input client_data, output ready);
endinterface

interface fwpb_rsp_if;
  logic                            valid;
  logic                            ready;
  logic                            taken_valid;
  logic [fwpb_pkg::KindWidth-1:0]  taken_kind;
  logic [31:0]                     taken_data;
  logic [fwpb_pkg::StatWidth-1:0]  status;
  logic [fwpb_pkg::CountWidth-1:0] fill_level;
  logic                            is_empty;

  modport source (output valid, output taken_valid, output taken_kind,
                  output taken_data, output status, output fill_level,
                  output is_empty, input ready);
  modport sink   (input valid, input taken_valid, input taken_kind,
                  input taken_data, input status, input fill_level,
                  input is_empty, output ready);
endinterface

>>> rtl/fifo_with_priority_bypass.sv
`timescale 1ns / 1ps
// A command's result is registered and offered in the cycle after its transfer.
// Throughput: one command per cycle; every cell updates in the same cycle, so
// the next command may follow at once while the response side keeps up.
// Reset clears the fill count and the response valid flag and sets the special
// kind to 'E'; slot contents are not reset and are never read before written.
// ----------------------------------------------------------------------------
// fifo_with_priority_bypass: ordered queue with head insert and class extract
// A row of cells holds the entries, head in cell 0. Commands append at the
// tail, push at the head, pop the head, extract the special entry nearest the
// head, or clear. Each command gives one response.
// ----------------------------------------------------------------------------
module fifo_with_priority_bypass (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fwpb_pkg::KindWidth-1:0] cfg_wdata_i,
  fwpb_req_if.sink                       req,
  fwpb_rsp_if.source                     rsp
);
  import fwpb_pkg::*;

  // Configuration register: the kind byte that marks special entries.
  logic [KindWidth-1:0] special_kind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      special_kind_q <= SpecialKindReset;
    end else if (cfg_we_i) begin
      special_kind_q <= cfg_wdata_i;
    end
  end

  // Fill count and handshake.
  logic [CountWidth-1:0] count_q, count_d;
  logic                  accept;
  logic                  full;
  logic                  empty;
  cmd_e                  cmd;

  assign accept = req.valid & req.ready;
  assign cmd    = cmd_e'(req.command);
  assign full   = (count_q == CountWidth'(QueueDepth));
  assign empty  = (count_q == '0);

  // Cell row wiring. The hit chain runs from the head toward the tail.
  cell_ctrl_t           ctrl   [QueueDepth];
  logic [KindWidth-1:0] kind_w [QueueDepth];
  logic [DataWidth-1:0] data_w [QueueDepth];
  logic                 taken_w[QueueDepth];
  logic [QueueDepth:0]  hit_w;

  assign hit_w[0] = 1'b0;

  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    logic [KindWidth-1:0] left_kind;
    logic [DataWidth-1:0] left_data;
    logic [KindWidth-1:0] right_kind;
    logic [DataWidth-1:0] right_data;

    // The head has no left neighbor and the last cell no right one; the
    // constants they take in are never counted as entries.
    if (i == 0) begin : g_head
      assign left_kind = '0;
      assign left_data = '0;
    end else begin : g_body
      assign left_kind = kind_w[i-1];
      assign left_data = data_w[i-1];
    end
    if (i == QueueDepth - 1) begin : g_last
      assign right_kind = '0;
      assign right_data = '0;
    end else begin : g_inner
      assign right_kind = kind_w[i+1];
      assign right_data = data_w[i+1];
    end

    // Per-cell command decode.
    always_comb begin
      ctrl[i].occupied = (CountWidth'(i) < count_q);
      ctrl[i].serve    = accept && (cmd == CmdServe);
      ctrl[i].op       = OpHold;
      if (accept) begin
        case (cmd)
          CmdAppend: begin
            if (!full && (count_q == CountWidth'(i))) begin
              ctrl[i].op = OpLoad;
            end
          end
          CmdPush: begin
            if (!full) begin
              ctrl[i].op = (i == 0) ? OpLoad : OpLeft;
            end
          end
          CmdPop: begin
            if (!empty) begin
              ctrl[i].op = OpRight;
            end
          end
          default: ctrl[i].op = OpHold;
        endcase
      end
    end

    fwpb_cell u_cell (
      .clk_i          (clk_i),
      .ctrl_i         (ctrl[i]),
      .special_kind_i (special_kind_q),
      .new_kind_i     (req.client_kind),
      .new_data_i     (req.client_data),
      .left_kind_i    (left_kind),
      .left_data_i    (left_data),
      .right_kind_i   (right_kind),
      .right_data_i   (right_data),
      .hit_i          (hit_w[i]),
      .hit_o          (hit_w[i+1]),
      .taken_o        (taken_w[i]),
      .kind_o         (kind_w[i]),
      .data_o         (data_w[i])
    );
  end

  // The matched entry is selected by an OR of one-hot masked slots.
  logic [KindWidth-1:0] serve_kind;
  logic [DataWidth-1:0] serve_data;
  logic                 serve_found;

  assign serve_found = hit_w[QueueDepth];

  always_comb begin
    serve_kind = '0;
    serve_data = '0;
    for (int i = 0; i < QueueDepth; i++) begin
      if (taken_w[i]) begin
        serve_kind = serve_kind | kind_w[i];
        serve_data = serve_data | data_w[i];
      end
    end
  end

  // Result of the command in flight and the next fill count.
  logic                 res_taken;
  logic [KindWidth-1:0] res_kind;
  logic [DataWidth-1:0] res_data;
  status_e              res_status;

  always_comb begin
    count_d    = count_q;
    res_taken  = 1'b0;
    res_kind   = '0;
    res_data   = '0;
    res_status = StatOk;
    case (cmd)
      CmdAppend, CmdPush: begin
        if (full) begin
          res_status = StatFull;
        end else begin
          count_d = count_q + CountWidth'(1);
        end
      end
      CmdPop: begin
        if (empty) begin
          res_status = StatEmpty;
        end else begin
          count_d   = count_q - CountWidth'(1);
          res_taken = 1'b1;
          res_kind  = kind_w[0];
          res_data  = data_w[0];
        end
      end
      CmdServe: begin
        if (serve_found) begin
          count_d   = count_q - CountWidth'(1);
          res_taken = 1'b1;
          res_kind  = serve_kind;
          res_data  = serve_data;
        end else begin
          res_status = StatNoSpecial;
        end
      end
      CmdClear: count_d = '0;
      default:  count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (accept) begin
      count_q <= count_d;
    end
  end

  // Response register. A new command is taken whenever the register is free
  // or its result is being transferred in the same cycle.
  logic                  rsp_valid_q;
  logic                  taken_valid_q;
  logic [KindWidth-1:0]  taken_kind_q;
  logic [DataWidth-1:0]  taken_data_q;
  status_e               status_q;
  logic [CountWidth-1:0] fill_q;

  assign req.ready = ~rsp_valid_q | rsp.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (accept) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      taken_valid_q <= res_taken;
      taken_kind_q  <= res_kind;
      taken_data_q  <= res_data;
      status_q      <= res_status;
      fill_q        <= count_d;
    end
  end

  assign rsp.valid       = rsp_valid_q;
  assign rsp.taken_valid = taken_valid_q;
  assign rsp.taken_kind  = taken_kind_q;
  assign rsp.taken_data  = taken_data_q;
  assign rsp.status      = status_q;
  assign rsp.fill_level  = fill_q;
  assign rsp.is_empty    = (fill_q == '0);

endmodule

>>> rtl/fwpb_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwpb_cell: one slot of the queue
// Holds one entry and moves it to or from its neighbors as commanded.
// ----------------------------------------------------------------------------
module fwpb_cell (
  input  logic                           clk_i,
  input  fwpb_pkg::cell_ctrl_t           ctrl_i,
  input  logic [fwpb_pkg::KindWidth-1:0] special_kind_i,
  input  logic [fwpb_pkg::KindWidth-1:0] new_kind_i,
  input  logic [fwpb_pkg::DataWidth-1:0] new_data_i,
  input  logic [fwpb_pkg::KindWidth-1:0] left_kind_i,
  input  logic [fwpb_pkg::DataWidth-1:0] left_data_i,
  input  logic [fwpb_pkg::KindWidth-1:0] right_kind_i,
  input  logic [fwpb_pkg::DataWidth-1:0] right_data_i,
  input  logic                           hit_i,
  output logic                           hit_o,
  output logic                           taken_o,
  output logic [fwpb_pkg::KindWidth-1:0] kind_o,
  output logic [fwpb_pkg::DataWidth-1:0] data_o
);
  import fwpb_pkg::*;

  logic [KindWidth-1:0] kind_q, kind_d;
  logic [DataWidth-1:0] data_q, data_d;
  logic                 match;

  // A match counts only in an occupied slot; the chain carries whether any
  // slot nearer the head already matched.
  assign match   = ctrl_i.occupied && (kind_q == special_kind_i);
  assign hit_o   = hit_i | match;
  assign taken_o = match & ~hit_i;
  assign kind_o  = kind_q;
  assign data_o  = data_q;

  always_comb begin
    kind_d = kind_q;
    data_d = data_q;
    if (ctrl_i.serve) begin
      // The matched slot and every slot behind it close the gap.
      if (hit_o) begin
        kind_d = right_kind_i;
        data_d = right_data_i;
      end
    end else begin
      case (ctrl_i.op)
        OpLoad: begin
          kind_d = new_kind_i;
          data_d = new_data_i;
        end
        OpLeft: begin
          kind_d = left_kind_i;
          data_d = left_data_i;
        end
        OpRight: begin
          kind_d = right_kind_i;
          data_d = right_data_i;
        end
        default: begin
          kind_d = kind_q;
          data_d = data_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    data_q <= data_d;
  end

endmodule
